>>> hdl/tf192_pkg.sv
`default_nettype none
package tf192_pkg;

  // Input and result items
  typedef struct packed {
    logic        op;
    logic [63:0] block_in_low;
    logic [63:0] block_in_high;
  } in_item_t;

  typedef struct packed {
    logic [63:0] block_out_low;
    logic [63:0] block_out_high;
  } out_item_t;

  // State carried between pipeline stages: direction and the four words
  typedef struct packed {
    logic             op;
    logic [3:0][31:0] x;
  } stage_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [1:0] CFG_KEY_MID  = 2'd1;
  localparam logic [1:0] CFG_KEY_HIGH = 2'd2;

  localparam int SUBKEY_COUNT = 40;
  localparam int SUBKEY_PAIRS = SUBKEY_COUNT / 2;
  localparam int ROUNDS       = 16;
  localparam logic OP_DECRYPT = 1'b1;

  // Key schedule sequencer
  typedef enum logic [1:0] {
    KS_IDLE,
    KS_HASH,
    KS_STORE
  } ks_state_e;

  localparam logic [8:0] GF_MDS_POLY = 9'h169;
  localparam logic [8:0] GF_RS_POLY  = 9'h14D;

  // q permutation nibble tables, entry i at bits [4i+3:4i]
  localparam logic [63:0] Q0_T0 = 64'h4ACE95B023F6D718;
  localparam logic [63:0] Q0_T1 = 64'hD9076A4F53218BCE;
  localparam logic [63:0] Q0_T2 = 64'h17423F8C09D6E5AB;
  localparam logic [63:0] Q0_T3 = 64'hAC5803B9E6214F7D;
  localparam logic [63:0] Q1_T0 = 64'h5CA04913E67FDB82;
  localparam logic [63:0] Q1_T1 = 64'h809F5AD673C4B2E1;
  localparam logic [63:0] Q1_T2 = 64'hF3B28DE0A96157C4;
  localparam logic [63:0] Q1_T3 = 64'hA802F746ED3C159B;

  localparam logic [7:0] MDS_M [4][4] = '{
    '{8'h01, 8'hEF, 8'h5B, 8'h5B},
    '{8'h5B, 8'hEF, 8'hEF, 8'h01},
    '{8'hEF, 8'h5B, 8'h01, 8'hEF},
    '{8'hEF, 8'h01, 8'hEF, 8'h5B}
  };

  localparam logic [7:0] RS_M [4][8] = '{
    '{8'h01, 8'hA4, 8'h55, 8'h87, 8'h5A, 8'h58, 8'hDB, 8'h9E},
    '{8'hA4, 8'h56, 8'h82, 8'hF3, 8'h1E, 8'hC6, 8'h68, 8'hE5},
    '{8'h02, 8'hA1, 8'hFC, 8'hC1, 8'h47, 8'hAE, 8'h3D, 8'h19},
    '{8'hA4, 8'h55, 8'h87, 8'h5A, 8'h58, 8'hDB, 8'h9E, 8'h03}
  };

  function automatic logic [31:0] rol8(input logic [31:0] v);
    return {v[23:0], v[31:24]};
  endfunction

  function automatic logic [31:0] rol1(input logic [31:0] v);
    return {v[30:0], v[31]};
  endfunction

  function automatic logic [31:0] ror1(input logic [31:0] v);
    return {v[0], v[31:1]};
  endfunction

  function automatic logic [31:0] rol9(input logic [31:0] v);
    return {v[22:0], v[31:23]};
  endfunction

  function automatic logic [3:0] ror4(input logic [3:0] v);
    return {v[0], v[3:1]};
  endfunction

  function automatic logic [3:0] nib(input logic [63:0] t, input logic [3:0] i);
    return t[{i, 2'b00} +: 4];
  endfunction

  // q0 (sel=0) or q1 (sel=1)
  function automatic logic [7:0] qperm(input logic sel, input logic [7:0] v);
    logic [63:0] t0, t1, t2, t3;
    logic [3:0]  a1, b1, a2, b2, a3, b3, a4, b4;
    t0 = sel ? Q1_T0 : Q0_T0;
    t1 = sel ? Q1_T1 : Q0_T1;
    t2 = sel ? Q1_T2 : Q0_T2;
    t3 = sel ? Q1_T3 : Q0_T3;
    a1 = v[7:4] ^ v[3:0];
    b1 = v[7:4] ^ ror4(v[3:0]) ^ {v[4], 3'b000};
    a2 = nib(t0, a1);
    b2 = nib(t1, b1);
    a3 = a2 ^ b2;
    b3 = a2 ^ ror4(b2) ^ {a2[0], 3'b000};
    a4 = nib(t2, a3);
    b4 = nib(t3, b3);
    return {b4, a4};
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                        input logic [8:0] poly);
    logic [8:0] x;
    logic [7:0] r;
    x = {1'b0, a};
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ x[7:0];
      x = {x[7:0], 1'b0};
      if (x[8]) x = x ^ poly;
    end
    return r;
  endfunction

  // h function with key words l0, l1, l2 (l2 applied first)
  function automatic logic [31:0] hfun(input logic [31:0] v, input logic [31:0] l0,
                                       input logic [31:0] l1, input logic [31:0] l2);
    logic [3:0][7:0] y;
    logic [3:0][7:0] z;
    logic [7:0]      acc;
    y[0] = qperm(1'b1, v[7:0])   ^ l2[7:0];
    y[1] = qperm(1'b1, v[15:8])  ^ l2[15:8];
    y[2] = qperm(1'b0, v[23:16]) ^ l2[23:16];
    y[3] = qperm(1'b0, v[31:24]) ^ l2[31:24];
    y[0] = qperm(1'b1, qperm(1'b0, qperm(1'b0, y[0]) ^ l1[7:0])   ^ l0[7:0]);
    y[1] = qperm(1'b0, qperm(1'b0, qperm(1'b1, y[1]) ^ l1[15:8])  ^ l0[15:8]);
    y[2] = qperm(1'b1, qperm(1'b1, qperm(1'b0, y[2]) ^ l1[23:16]) ^ l0[23:16]);
    y[3] = qperm(1'b0, qperm(1'b1, qperm(1'b1, y[3]) ^ l1[31:24]) ^ l0[31:24]);
    for (int i = 0; i < 4; i++) begin
      acc = 8'h00;
      for (int j = 0; j < 4; j++) acc = acc ^ gf_mul(MDS_M[i][j], y[j], GF_MDS_POLY);
      z[i] = acc;
    end
    return z;
  endfunction

  // RS code over one 64-bit key group
  function automatic logic [31:0] rs_word(input logic [63:0] k);
    logic [3:0][7:0] w;
    logic [7:0]      acc;
    for (int i = 0; i < 4; i++) begin
      acc = 8'h00;
      for (int j = 0; j < 8; j++) acc = acc ^ gf_mul(RS_M[i][j], k[8*j +: 8], GF_RS_POLY);
      w[i] = acc;
    end
    return w;
  endfunction

endpackage
`default_nettype wire

>>> hdl/tf192_key_sched.sv
`default_nettype none
module tf192_key_sched (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [1:0]                            cfg_idx_i,
  input  logic [63:0]                           cfg_wdata_i,
  output logic                                  busy_o,
  output logic [tf192_pkg::SUBKEY_COUNT-1:0][31:0] subkeys_o,
  output logic [2:0][31:0]                      sbox_o
);
  import tf192_pkg::*;

  ks_state_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic [2:0][63:0] key_q;
  logic [31:0] a_q, b_q;
  logic [SUBKEY_COUNT-1:0][31:0] sk_q;
  logic [2:0][31:0] sbox_q;
  logic key_wr;
  logic [7:0] even_b, odd_b;

  assign key_wr = cfg_we_i && (cfg_idx_i == CFG_KEY_LOW || cfg_idx_i == CFG_KEY_MID ||
                               cfg_idx_i == CFG_KEY_HIGH);
  assign even_b = {2'b00, cnt_q, 1'b0};
  assign odd_b  = {2'b00, cnt_q, 1'b1};

  // Control registers; reset expands the all-zero key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= KS_HASH;
      cnt_q   <= 5'd0;
      key_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_KEY_LOW)  key_q[0] <= cfg_wdata_i;
        if (cfg_idx_i == CFG_KEY_MID)  key_q[1] <= cfg_wdata_i;
        if (cfg_idx_i == CFG_KEY_HIGH) key_q[2] <= cfg_wdata_i;
      end
    end
  end

  // Sequencer: hash one subkey pair, then store it
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      KS_IDLE:  ;
      KS_HASH:  state_d = KS_STORE;
      KS_STORE: begin
        if (cnt_q == 5'(SUBKEY_PAIRS - 1)) begin
          state_d = KS_IDLE;
        end else begin
          state_d = KS_HASH;
          cnt_d   = cnt_q + 5'd1;
        end
      end
      default:  state_d = KS_IDLE;
    endcase
    if (key_wr) begin
      state_d = KS_HASH;
      cnt_d   = 5'd0;
    end
  end

  // Datapath: h of even/odd words and the RS S-box words, then PHT into the subkey registers
  always_ff @(posedge clk_i) begin
    if (state_q == KS_HASH) begin
      a_q <= hfun({4{even_b}}, key_q[0][31:0], key_q[1][31:0], key_q[2][31:0]);
      b_q <= rol8(hfun({4{odd_b}}, key_q[0][63:32], key_q[1][63:32], key_q[2][63:32]));
      sbox_q[2] <= rs_word(key_q[0]);
      sbox_q[1] <= rs_word(key_q[1]);
      sbox_q[0] <= rs_word(key_q[2]);
    end
    if (state_q == KS_STORE) begin
      sk_q[{cnt_q, 1'b0}] <= a_q + b_q;
      sk_q[{cnt_q, 1'b1}] <= rol9(a_q + {b_q[30:0], 1'b0});
    end
  end

  assign busy_o    = (state_q != KS_IDLE);
  assign subkeys_o = sk_q;
  assign sbox_o    = sbox_q;

endmodule
`default_nettype wire

>>> hdl/tf192_round.sv
`default_nettype none
module tf192_round (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  tf192_pkg::stage_t         data_i,
  input  logic [2:0][31:0]          sbox_i,
  input  logic [1:0][31:0]          k_enc_i,
  input  logic [1:0][31:0]          k_dec_i,
  output logic                      valid_o,
  output tf192_pkg::stage_t         data_o
);
  import tf192_pkg::*;

  logic   vb_q, vo_q;
  stage_t sb_q, so_q;
  logic [31:0] t0_q, t1_q, f0, f1;
  logic [1:0][31:0] k;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      vb_q <= valid_i;
      vo_q <= vb_q;
    end
  end

  // First half: the two g functions
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sb_q <= data_i;
      t0_q <= hfun(data_i.x[0], sbox_i[0], sbox_i[1], sbox_i[2]);
      t1_q <= hfun(rol8(data_i.x[1]), sbox_i[0], sbox_i[1], sbox_i[2]);
    end
  end

  // Second half: PHT, subkey add, mix into the other half and swap
  assign k  = (sb_q.op == OP_DECRYPT) ? k_dec_i : k_enc_i;
  assign f0 = t0_q + t1_q + k[0];
  assign f1 = t0_q + {t1_q[30:0], 1'b0} + k[1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      so_q.op   <= sb_q.op;
      so_q.x[2] <= sb_q.x[0];
      so_q.x[3] <= sb_q.x[1];
      if (sb_q.op == OP_DECRYPT) begin
        so_q.x[0] <= rol1(sb_q.x[2]) ^ f0;
        so_q.x[1] <= ror1(sb_q.x[3] ^ f1);
      end else begin
        so_q.x[0] <= ror1(sb_q.x[2] ^ f0);
        so_q.x[1] <= rol1(sb_q.x[3]) ^ f1;
      end
    end
  end

  assign valid_o = vo_q;
  assign data_o  = so_q;

endmodule
`default_nettype wire

>>> hdl/twofish192_block_cipher.sv
// Twofish with a 192-bit key on 128-bit blocks. Write key_low, key_mid and key_high
// (indexes 0..2) while the block is idle; each write, and reset, starts a key schedule
// over 20 subkey pairs, each hashed with one h-function pair and then stored, during
// which in_stall_o stays high. After that the block takes one item per cycle while
// the output is not stalled, encrypt or decrypt mixed freely, and returns each result
// through one whitening stage, two stages per Feistel round for 16 rounds, and one
// output stage. An output stall while a result is held freezes the whole pipeline.
`default_nettype none
module twofish192_block_cipher (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [63:0]           cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  tf192_pkg::in_item_t   in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output tf192_pkg::out_item_t  out_item_o
);
  import tf192_pkg::*;

  logic ks_busy, en;
  logic [SUBKEY_COUNT-1:0][31:0] sk;
  logic [2:0][31:0] sbox;
  logic   v [ROUNDS+1];
  stage_t st [ROUNDS+1];
  logic   v0_q, vout_q;
  stage_t s0_q;
  out_item_t out_q;
  logic [3:0][31:0] w, kin, kout;

  tf192_key_sched u_ks (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .busy_o     (ks_busy),
    .subkeys_o  (sk),
    .sbox_o     (sbox)
  );

  // Pipeline advances unless a finished result is held
  assign en         = !(vout_q && out_stall_i);
  assign in_stall_o = ks_busy || !en;

  // Input whitening
  assign w   = {in_item_i.block_in_high, in_item_i.block_in_low};
  assign kin = (in_item_i.op == OP_DECRYPT) ? sk[7:4] : sk[3:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      vout_q <= 1'b0;
    end else if (en) begin
      v0_q   <= in_valid_i && !in_stall_o;
      vout_q <= v[ROUNDS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q.op <= in_item_i.op;
      s0_q.x  <= w ^ kin;
    end
  end

  assign v[0]  = v0_q;
  assign st[0] = s0_q;

  // Rounds; decryption walks the subkeys backward
  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    tf192_round u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(v[r]),
      .data_i (st[r]),
      .sbox_i (sbox),
      .k_enc_i(sk[2*r+9 : 2*r+8]),
      .k_dec_i(sk[2*(ROUNDS-1-r)+9 : 2*(ROUNDS-1-r)+8]),
      .valid_o(v[r+1]),
      .data_o (st[r+1])
    );
  end

  // Output whitening with the final swap undone
  assign kout = (st[ROUNDS].op == OP_DECRYPT) ? sk[3:0] : sk[7:4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.block_out_low  <= {st[ROUNDS].x[3] ^ kout[1], st[ROUNDS].x[2] ^ kout[0]};
      out_q.block_out_high <= {st[ROUNDS].x[1] ^ kout[3], st[ROUNDS].x[0] ^ kout[2]};
    end
  end

  assign out_valid_o = vout_q;
  assign out_item_o  = out_q;

  // No item enters while the key schedule runs
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ks_busy |-> in_stall_o) else $error("item accepted during key schedule");

  // A key write always restarts the schedule
  a_key_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_idx_i == CFG_KEY_LOW || cfg_idx_i == CFG_KEY_MID ||
                  cfg_idx_i == CFG_KEY_HIGH)) |=> ks_busy)
    else $error("key write did not start schedule");

  // A held result freezes the pipeline input
  a_hold_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while output held");

endmodule
`default_nettype wire

>>> verif/twofish192_block_cipher_tb.sv
`default_nettype none
module twofish192_block_cipher_tb;
  import tf192_pkg::*;

  localparam int LATENCY = 34;
  localparam int N_RANDOM = 1850;

  // Subkey and S-box key state, kept in step with the key registers
  logic [63:0] key_reg [3];
  logic [31:0] subkey [40];
  logic [31:0] sbk [3];   // S2, S1, S0 in h-function order L0, L1, L2

  localparam logic [7:0] QT [2][4][16] = '{
    '{'{8'h8,8'h1,8'h7,8'hD,8'h6,8'hF,8'h3,8'h2,8'h0,8'hB,8'h5,8'h9,8'hE,8'hC,8'hA,8'h4},
      '{8'hE,8'hC,8'hB,8'h8,8'h1,8'h2,8'h3,8'h5,8'hF,8'h4,8'hA,8'h6,8'h7,8'h0,8'h9,8'hD},
      '{8'hB,8'hA,8'h5,8'hE,8'h6,8'hD,8'h9,8'h0,8'hC,8'h8,8'hF,8'h3,8'h2,8'h4,8'h7,8'h1},
      '{8'hD,8'h7,8'hF,8'h4,8'h1,8'h2,8'h6,8'hE,8'h9,8'hB,8'h3,8'h0,8'h8,8'h5,8'hC,8'hA}},
    '{'{8'h2,8'h8,8'hB,8'hD,8'hF,8'h7,8'h6,8'hE,8'h3,8'h1,8'h9,8'h4,8'h0,8'hA,8'hC,8'h5},
      '{8'h1,8'hE,8'h2,8'hB,8'h4,8'hC,8'h3,8'h7,8'h6,8'hD,8'hA,8'h5,8'hF,8'h9,8'h0,8'h8},
      '{8'h4,8'hC,8'h7,8'h5,8'h1,8'h6,8'h9,8'hA,8'h0,8'hE,8'hD,8'h8,8'h2,8'hB,8'h3,8'hF},
      '{8'hB,8'h9,8'h5,8'h1,8'hC,8'h3,8'hD,8'hE,8'h6,8'h4,8'h7,8'hF,8'h2,8'h0,8'h8,8'hA}}};

  localparam logic [7:0] MDS [4][4] = '{'{8'h01,8'hEF,8'h5B,8'h5B},'{8'h5B,8'hEF,8'hEF,8'h01},
                                        '{8'hEF,8'h5B,8'h01,8'hEF},'{8'hEF,8'h01,8'hEF,8'h5B}};
  localparam logic [7:0] RS [4][8] = '{
    '{8'h01,8'hA4,8'h55,8'h87,8'h5A,8'h58,8'hDB,8'h9E},
    '{8'hA4,8'h56,8'h82,8'hF3,8'h1E,8'hC6,8'h68,8'hE5},
    '{8'h02,8'hA1,8'hFC,8'hC1,8'h47,8'hAE,8'h3D,8'h19},
    '{8'hA4,8'h55,8'h87,8'h5A,8'h58,8'hDB,8'h9E,8'h03}};

  function automatic logic [31:0] rotl(logic [31:0] x, int n);
    return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
  endfunction

  function automatic logic [3:0] nib_rot(logic [3:0] v);
    return {v[0], v[3:1]};
  endfunction

  function automatic logic [7:0] q_byte(int s, logic [7:0] x);
    logic [3:0] a, b, a2, b2, a3, b3;
    a = x[7:4] ^ x[3:0];
    b = x[7:4] ^ nib_rot(x[3:0]) ^ {x[4], 3'b000};
    a2 = QT[s][0][a][3:0];
    b2 = QT[s][1][b][3:0];
    a3 = a2 ^ b2;
    b3 = a2 ^ nib_rot(b2) ^ {a2[0], 3'b000};
    return {QT[s][3][b3][3:0], QT[s][2][a3][3:0]};
  endfunction

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b, logic [8:0] p);
    logic [8:0] x;
    logic [7:0] r;
    x = {1'b0, a};
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= x[7:0];
      x = x << 1;
      if (x[8]) x ^= p;
    end
    return r;
  endfunction

  function automatic logic [31:0] h_word(logic [31:0] x, logic [31:0] l0, logic [31:0] l1,
                                         logic [31:0] l2);
    logic [7:0] y [4];
    logic [31:0] z;
    logic [7:0] acc;
    y[0] = q_byte(1, x[7:0]) ^ l2[7:0];
    y[1] = q_byte(1, x[15:8]) ^ l2[15:8];
    y[2] = q_byte(0, x[23:16]) ^ l2[23:16];
    y[3] = q_byte(0, x[31:24]) ^ l2[31:24];
    y[0] = q_byte(1, q_byte(0, q_byte(0, y[0]) ^ l1[7:0]) ^ l0[7:0]);
    y[1] = q_byte(0, q_byte(0, q_byte(1, y[1]) ^ l1[15:8]) ^ l0[15:8]);
    y[2] = q_byte(1, q_byte(1, q_byte(0, y[2]) ^ l1[23:16]) ^ l0[23:16]);
    y[3] = q_byte(0, q_byte(1, q_byte(1, y[3]) ^ l1[31:24]) ^ l0[31:24]);
    z = '0;
    for (int i = 0; i < 4; i++) begin
      acc = '0;
      for (int j = 0; j < 4; j++) acc ^= gmul(MDS[i][j], y[j], 9'h169);
      z[8*i +: 8] = acc;
    end
    return z;
  endfunction

  // Rebuild subkeys and S-box words from the current key registers
  task automatic derive_key_schedule();
    logic [31:0] me [3], mo [3];
    logic [31:0] w, a, b;
    logic [7:0] acc;
    for (int g = 0; g < 3; g++) begin
      me[g] = key_reg[g][31:0];
      mo[g] = key_reg[g][63:32];
      for (int i = 0; i < 4; i++) begin
        acc = '0;
        for (int j = 0; j < 8; j++) acc ^= gmul(RS[i][j], key_reg[g][8*j +: 8], 9'h14D);
        w[8*i +: 8] = acc;
      end
      sbk[2 - g] = w;
    end
    for (int i = 0; i < 20; i++) begin
      a = h_word(32'(2 * i) * 32'h01010101, me[0], me[1], me[2]);
      b = rotl(h_word(32'(2 * i + 1) * 32'h01010101, mo[0], mo[1], mo[2]), 8);
      subkey[2*i] = a + b;
      subkey[2*i+1] = rotl(a + 2 * b, 9);
    end
  endtask

  function automatic out_item_t cipher_block(in_item_t it);
    logic [31:0] w [4];
    logic [31:0] t0, t1, f0, f1, n2, n3, a0, a1;
    out_item_t o;
    w[0] = it.block_in_low[31:0];  w[1] = it.block_in_low[63:32];
    w[2] = it.block_in_high[31:0]; w[3] = it.block_in_high[63:32];
    if (it.op != OP_DECRYPT) begin
      for (int i = 0; i < 4; i++) w[i] ^= subkey[i];
      for (int r = 0; r < 16; r++) begin
        t0 = h_word(w[0], sbk[0], sbk[1], sbk[2]);
        t1 = h_word(rotl(w[1], 8), sbk[0], sbk[1], sbk[2]);
        f0 = t0 + t1 + subkey[2*r+8];
        f1 = t0 + 2 * t1 + subkey[2*r+9];
        n2 = rotl(w[2] ^ f0, 31);
        n3 = rotl(w[3], 1) ^ f1;
        w[2] = w[0]; w[3] = w[1]; w[0] = n2; w[1] = n3;
      end
      n2 = w[0]; n3 = w[1];
      w[0] = w[2] ^ subkey[4]; w[1] = w[3] ^ subkey[5];
      w[2] = n2 ^ subkey[6];   w[3] = n3 ^ subkey[7];
    end else begin
      a0 = w[0] ^ subkey[4]; a1 = w[1] ^ subkey[5];
      w[0] = w[2] ^ subkey[6]; w[1] = w[3] ^ subkey[7];
      w[2] = a0; w[3] = a1;
      for (int r = 15; r >= 0; r--) begin
        t0 = h_word(w[2], sbk[0], sbk[1], sbk[2]);
        t1 = h_word(rotl(w[3], 8), sbk[0], sbk[1], sbk[2]);
        f0 = t0 + t1 + subkey[2*r+8];
        f1 = t0 + 2 * t1 + subkey[2*r+9];
        n2 = rotl(w[0], 1) ^ f0;
        n3 = rotl(w[1] ^ f1, 31);
        w[0] = w[2]; w[1] = w[3]; w[2] = n2; w[3] = n3;
      end
      for (int i = 0; i < 4; i++) w[i] ^= subkey[i];
    end
    o.block_out_low = {w[1], w[0]};
    o.block_out_high = {w[3], w[2]};
    return o;
  endfunction

  // Holds predicted blocks in order and compares what comes out
  class block_scoreboard;
    out_item_t pending[$];
    int errors;
    int checked;

    function void note_input(in_item_t it);
      pending.push_back(cipher_block(it));
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
        return;
      end
      exp = pending.pop_front();
      if (got.block_out_low !== exp.block_out_low) begin
        errors++;
        $display("%0t: block_out_low expected %h actual %h", $time, exp.block_out_low,
                 got.block_out_low);
      end
      if (got.block_out_high !== exp.block_out_high) begin
        errors++;
        $display("%0t: block_out_high expected %h actual %h", $time, exp.block_out_high,
                 got.block_out_high);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [1:0] cfg_idx_i = '0;
  logic [63:0] cfg_wdata_i = '0;
  logic in_valid_i = 0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 0;
  out_item_t out_item_o;

  block_scoreboard sb = new();
  bit sink_quiet = 0;     // no random output stalls
  bit sink_hold = 0;      // long output hold-off request
  int n_enc, n_dec;

  always #5 clk_i = ~clk_i;

  twofish192_block_cipher dut (.*);

  // Record accepted items and check results at the edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sb.note_input(in_item_i);
      if (in_item_i.op) n_dec++; else n_enc++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_item_o);
  end

  // Output stall: random bursts, or a long hold when asked
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (sink_hold) begin
        out_stall_i <= 1;
        repeat (200) @(posedge clk_i);
        out_stall_i <= 0;
        sink_hold = 0;
      end else if (!sink_quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 13);
        out_stall_i <= 1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 0;
      end
      @(posedge clk_i);
    end
  end

  task automatic write_key(logic [1:0] idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    if (idx <= CFG_KEY_HIGH) begin
      key_reg[idx] = val;
      derive_key_schedule();
    end
  endtask

  // Offer one item and hold it until taken; valid stays up for the next item
  task automatic send_block(in_item_t it, bit gaps);
    int n;
    if (gaps && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 13);
      in_valid_i <= 0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 6) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.op = 1'($urandom_range(0, 1));
    it.block_in_low = rand64();
    it.block_in_high = rand64();
    return it;
  endfunction

  initial begin
    in_item_t it;
    logic [63:0] edges [4];
    key_reg[0] = '0; key_reg[1] = '0; key_reg[2] = '0;
    derive_key_schedule();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;

    // Directed: all-zero key, then field extremes both directions
    edges[0] = '0; edges[1] = '1; edges[2] = 64'h8000000000000001;
    edges[3] = 64'h0123456789ABCDEF;
    for (int i = 0; i < 4; i++)
      for (int d = 0; d < 2; d++) begin
        it.op = d[0];
        it.block_in_low = edges[i];
        it.block_in_high = edges[3 - i];
        send_block(it, 0);
      end
    drain();
    // Out-of-range index is ignored
    write_key(2'd3, rand64());
    write_key(CFG_KEY_LOW, '1);
    write_key(CFG_KEY_MID, '1);
    write_key(CFG_KEY_HIGH, '1);
    for (int i = 0; i < 6; i++) send_block(rand_item(), 0);
    drain();
    // Random blocks under a fixed key
    write_key(CFG_KEY_LOW, 64'h0123456789ABCDEF);
    write_key(CFG_KEY_MID, 64'hFEDCBA9876543210);
    write_key(CFG_KEY_HIGH, 64'h0011223344556677);
    for (int i = 0; i < 6; i++) send_block(rand_item(), 0);
    drain();

    // Random phases, a new key for each
    for (int ph = 0; ph < 6; ph++) begin
      write_key(CFG_KEY_LOW, rand64());
      write_key(CFG_KEY_MID, rand64());
      write_key(CFG_KEY_HIGH, rand64());
      if (ph == 1) sink_hold = 1;
      for (int i = 0; i < N_RANDOM / 6; i++) begin
        if (ph == 5 && i > N_RANDOM / 12) sink_quiet = 1;
        if (ph == 2 && i == 100) begin
          in_valid_i <= 0;
          while (sb.pending.size() != 0) @(posedge clk_i);
        end
        send_block(rand_item(), !sink_quiet);
      end
      drain();
    end

    $display("covered %0d encrypt and %0d decrypt blocks, %0d results checked, 9 keys",
             n_enc, n_dec, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("twofish192_block_cipher_tb: done, clean");
    else
      $display("twofish192_block_cipher_tb: done, errors");
    $finish;
  end

  initial begin
    #3000000;
    $display("twofish192_block_cipher_tb: done, errors");
    $finish;
  end

endmodule
`default_nettype wire

>>> twofish192_block_cipher.f
hdl/tf192_pkg.sv
hdl/tf192_key_sched.sv
hdl/tf192_round.sv
hdl/twofish192_block_cipher.sv
verif/twofish192_block_cipher_tb.sv
